### src/skts_pkg.sv
// Package for the sorted key table: request and status codes, default sizes
// and the flag group that the controller hands to the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skts_pkg;

    localparam int DEFAULT_CAPACITY    = 16;
    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int KEY_W               = 32;
    localparam int REQ_W               = 2;
    localparam int STATUS_W            = 2;

    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic                at_end;
    } skts_flags_t;

endpackage

`default_nettype wire

### src/skts_cell_ram.sv
// Cell memory of the sorted key table: one write port and one read port
// with registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module skts_cell_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 96,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/skts_ctrl.sv
// Sequencer of the sorted key table: binary search, cell shift on insert and
// position read, all through the cell memory. Depends on skts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skts_ctrl #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 64,
    parameter int IDX_W       = 5,
    parameter int ADDR_W      = 4,
    parameter int WORD_W      = 96
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [skts_pkg::REQ_W-1:0] req_type,
    input  wire logic [skts_pkg::KEY_W-1:0] key,
    input  wire logic [VALUE_WIDTH-1:0]     payload_in,
    input  wire logic [IDX_W-1:0]           position,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output skts_pkg::skts_flags_t           res_flags,
    output logic      [IDX_W-1:0]           res_slot,
    output logic      [skts_pkg::KEY_W-1:0] res_key,
    output logic      [VALUE_WIDTH-1:0]     res_payload,
    output logic      [IDX_W-1:0]           res_count,
    output logic                            rd_en,
    output logic      [ADDR_W-1:0]          rd_addr,
    input  wire logic [WORD_W-1:0]          rd_data,
    output logic                            wr_en,
    output logic      [ADDR_W-1:0]          wr_addr,
    output logic      [WORD_W-1:0]          wr_data
);

    import skts_pkg::*;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_SEARCH = 3'd1;
    localparam logic [ST_W-1:0] ST_CMP    = 3'd2;
    localparam logic [ST_W-1:0] ST_DECIDE = 3'd3;
    localparam logic [ST_W-1:0] ST_SHIFT  = 3'd4;
    localparam logic [ST_W-1:0] ST_RDWAIT = 3'd5;
    localparam logic [ST_W-1:0] ST_FINISH = 3'd6;

    localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

    logic [ST_W-1:0]        state_reg, state_next;
    logic [IDX_W-1:0]       total_reg, total_next;
    logic [REQ_W-1:0]       req_reg, req_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VALUE_WIDTH-1:0] pay_reg, pay_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [IDX_W-1:0]       lo_reg, lo_next;
    logic [IDX_W-1:0]       hi_reg, hi_next;
    logic [ADDR_W-1:0]      mid_reg, mid_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    skts_flags_t            flags_reg, flags_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [KEY_W-1:0]       kout_reg, kout_next;
    logic [VALUE_WIDTH-1:0] pout_reg, pout_next;

    logic [IDX_W:0]         mid_sum;
    logic [IDX_W-1:0]       mid_full;
    logic [KEY_W-1:0]       rd_key;
    logic [IDX_W:0]         pos_plus;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full = mid_sum[IDX_W:1];
    assign rd_key   = rd_data[WORD_W-1:VALUE_WIDTH];
    assign pos_plus = {1'b0, pos_reg} + (IDX_W+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        pay_next       = pay_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        flags_next     = flags_reg;
        slot_next      = slot_reg;
        kout_next      = kout_reg;
        pout_next      = pout_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = req_type;
                    key_next = key;
                    pay_next = payload_in;
                    pos_next = position;
                    lo_next  = '0;
                    hi_next  = total_reg;
                    hit_next = 1'b0;
                    if (req_type == REQ_READ)
                    begin
                        slot_next = position;
                        if (position < total_reg)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_W'(position);
                            state_next = ST_RDWAIT;
                        end
                        else
                        begin
                            flags_next.status = STATUS_RANGE;
                            flags_next.found  = 1'b0;
                            flags_next.at_end = 1'b1;
                            kout_next         = '0;
                            pout_next         = '0;
                            state_next        = ST_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    idx_next   = lo_reg;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(mid_full);
                    mid_next   = ADDR_W'(mid_full);
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (key_reg == rd_key)
                begin
                    hit_next   = 1'b1;
                    idx_next   = IDX_W'(mid_reg);
                    state_next = ST_DECIDE;
                end
                else if (key_reg < rd_key)
                begin
                    hi_next    = IDX_W'(mid_reg);
                    state_next = ST_SEARCH;
                end
                else
                begin
                    lo_next    = IDX_W'(mid_reg) + IDX_W'(1);
                    state_next = ST_SEARCH;
                end
            end
            ST_DECIDE:
            begin
                flags_next.found  = hit_reg;
                flags_next.at_end = 1'b0;
                slot_next         = idx_reg;
                kout_next         = '0;
                pout_next         = '0;
                if (req_reg == REQ_INSERT && total_reg < CAP_IDX)
                begin
                    cnt_next   = total_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    flags_next.status = (req_reg == REQ_INSERT) ? STATUS_FULL : STATUS_OK;
                    state_next        = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg + ADDR_W'(1);
                    wr_data = rd_data;
                end
                if (cnt_reg > idx_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ADDR_W'(cnt_reg - IDX_W'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(cnt_reg - IDX_W'(1));
                    cnt_next       = cnt_reg - IDX_W'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    wr_en             = 1'b1;
                    wr_addr           = ADDR_W'(idx_reg);
                    wr_data           = {key_reg, pay_reg};
                    total_next        = total_reg + IDX_W'(1);
                    flags_next.status = STATUS_OK;
                    state_next        = ST_FINISH;
                end
            end
            ST_RDWAIT:
            begin
                flags_next.status = STATUS_OK;
                flags_next.found  = 1'b0;
                flags_next.at_end = (pos_plus >= {1'b0, total_reg});
                kout_next         = rd_key;
                pout_next         = rd_data[VALUE_WIDTH-1:0];
                state_next        = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        key_reg       <= key_next;
        pay_reg       <= pay_next;
        pos_reg       <= pos_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        cnt_reg       <= cnt_next;
        pend_addr_reg <= pend_addr_next;
        flags_reg     <= flags_next;
        slot_reg      <= slot_next;
        kout_reg      <= kout_next;
        pout_reg      <= pout_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign res_valid   = (state_reg == ST_FINISH);
    assign res_flags   = flags_reg;
    assign res_slot    = slot_reg;
    assign res_key     = kout_reg;
    assign res_payload = pout_reg;
    assign res_count   = total_reg;

endmodule

`default_nettype wire

### src/sorted_key_table_search_insert_core.sv
// Sorted key table: a read item takes a cell read, which a bad position skips; a find runs
// search probes until a hit or an empty range; an insert then moves the cells from the slot
// up by one before it writes. One item is worked at a time through the cell memory, and the
// next item is taken only after the result leaves.
// Reset empties the table at once; cell contents are not cleared. Depends on skts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_search_insert_core #(
    parameter int CAPACITY    = skts_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = skts_pkg::DEFAULT_VALUE_WIDTH,
    parameter int IDX_W       = $clog2(CAPACITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [skts_pkg::REQ_W-1:0]    req_type,
    input  wire logic [skts_pkg::KEY_W-1:0]    key,
    input  wire logic [VALUE_WIDTH-1:0]        payload_in,
    input  wire logic [IDX_W-1:0]              position,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [skts_pkg::STATUS_W-1:0] status,
    output logic                               found,
    output logic      [IDX_W-1:0]              slot,
    output logic      [skts_pkg::KEY_W-1:0]    key_out,
    output logic      [VALUE_WIDTH-1:0]        payload_out,
    output logic      [IDX_W-1:0]              cell_count,
    output logic                               at_end
);

    import skts_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int WORD_W = KEY_W + VALUE_WIDTH;

    logic                   res_valid;
    logic                   res_ready;
    skts_flags_t            res_flags;
    logic [IDX_W-1:0]       res_slot;
    logic [KEY_W-1:0]       res_key;
    logic [VALUE_WIDTH-1:0] res_payload;
    logic [IDX_W-1:0]       res_count;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [WORD_W-1:0]      rd_data;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [WORD_W-1:0]      wr_data;

    logic                   out_valid_reg, out_valid_next;
    skts_flags_t            flags_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [KEY_W-1:0]       key_out_reg;
    logic [VALUE_WIDTH-1:0] payload_out_reg;
    logic [IDX_W-1:0]       count_reg;
    logic                   load;

    skts_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W),
        .ADDR_W      (ADDR_W),
        .WORD_W      (WORD_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .key         (key),
        .payload_in  (payload_in),
        .position    (position),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_flags   (res_flags),
        .res_slot    (res_slot),
        .res_key     (res_key),
        .res_payload (res_payload),
        .res_count   (res_count),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    skts_cell_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg       <= res_flags;
            slot_reg        <= res_slot;
            key_out_reg     <= res_key;
            payload_out_reg <= res_payload;
            count_reg       <= res_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = flags_reg.status;
    assign found       = flags_reg.found;
    assign at_end      = flags_reg.at_end;
    assign slot        = slot_reg;
    assign key_out     = key_out_reg;
    assign payload_out = payload_out_reg;
    assign cell_count  = count_reg;

endmodule

`default_nettype wire

### src/skts_checker.sv
// Port-level checker for the sorted key table and the bind that attaches it
// to the top level. Depends on skts_pkg and sorted_key_table_search_insert_core.
`timescale 1ns / 1ps
`default_nettype none

module skts_checker #(
    parameter int CAPACITY    = skts_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = skts_pkg::DEFAULT_VALUE_WIDTH,
    parameter int IDX_W       = $clog2(CAPACITY + 1)
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [skts_pkg::STATUS_W-1:0] status,
    input wire logic                          found,
    input wire logic [IDX_W-1:0]              slot,
    input wire logic [skts_pkg::KEY_W-1:0]    key_out,
    input wire logic [VALUE_WIDTH-1:0]        payload_out,
    input wire logic [IDX_W-1:0]              cell_count,
    input wire logic                          at_end
);

    import skts_pkg::*;

    localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot)
            && $stable(key_out) && $stable(payload_out) && $stable(cell_count))
        else $error("Stalled result item changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input taken again right after an accepted item.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cell_count <= CAP_IDX)
        else $error("Cell count exceeds capacity.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |-> cell_count == CAP_IDX && at_end == 1'b0)
        else $error("Full status reported while the table is not full.");

    a_range_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_RANGE |-> at_end && !found && key_out == '0
            && payload_out == '0 && slot >= cell_count)
        else $error("Bad read position reported with inconsistent fields.");

endmodule

bind sorted_key_table_search_insert_core skts_checker #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W)
) u_skts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .slot        (slot),
    .key_out     (key_out),
    .payload_out (payload_out),
    .cell_count  (cell_count),
    .at_end      (at_end)
);

`default_nettype wire
